### rtl/core/lfs_pkg.sv
// lfs_pkg: shared types, codes and constants of the line follower steering core
// no dependencies; imported by every module of the core
package lfs_pkg;

  // fixed field widths
  localparam int SENSOR_COUNT = 6;
  localparam int THRESH_W     = 12;
  localparam int SPEED_W      = 7;
  localparam int GAIN_W       = 10;
  localparam int TIME_W       = 32;
  localparam int ERR_W        = 11;
  localparam int MAG_W        = 10;
  localparam int DRIVE_W      = 8;
  localparam int PROD_W       = 22;
  localparam int SECS_W       = 23;
  localparam int STEP_W       = 6;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 12;
  localparam int OUT_DATA_W   = 40;
  localparam int OUT_USER_W   = 2;

  typedef logic [SENSOR_COUNT-1:0] pattern_t;

  // sensor bit positions in the line pattern
  localparam pattern_t PAT_NONE = 6'h00;
  localparam pattern_t PAT_FL   = 6'h01;
  localparam pattern_t PAT_FR   = 6'h02;
  localparam pattern_t PAT_CL   = 6'h04;
  localparam pattern_t PAT_CR   = 6'h08;
  localparam pattern_t PAT_RL   = 6'h10;
  localparam pattern_t PAT_RR   = 6'h20;
  localparam pattern_t PAT_ALL  = 6'h3F;

  // steering error levels
  localparam logic signed [ERR_W-1:0] ERR_SMALL = 11'sd190;
  localparam logic signed [ERR_W-1:0] ERR_MID   = 11'sd550;
  localparam logic signed [ERR_W-1:0] ERR_BIG   = 11'sd700;

  // whole seconds from milliseconds: (ms * ceil(2^38 / 1000)) >> 38, exact for 32-bit ms
  localparam int                      SECS_RECIP_W = 29;
  localparam logic [SECS_RECIP_W-1:0] SECS_RECIP   = 29'd274877907;
  localparam int                      SECS_SHIFT   = 38;
  localparam logic [STEP_W-1:0] DERIV_STEPS = 6'd10;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_GAIN    = 2'd3;

  typedef enum logic [1:0] {
    ACT_DIFF  = 2'd0,
    ACT_PIVOT = 2'd1,
    ACT_LEFT  = 2'd2,
    ACT_RIGHT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SECS,
    S_DERIV,
    S_MUL,
    S_SUM,
    S_OUT
  } state_t;

  // pattern decode result
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic                    toggle;
    logic                    start;
    action_t                 dir;
  } decode_t;

  // divider request
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/lfs_sensor_lane.sv
// lfs_sensor_lane: one reflectance channel, compares a sample against the threshold
// depends on lfs_pkg
module lfs_sensor_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic [lfs_pkg::THRESH_W-1:0] threshold,
  output logic                         on_line
);
  import lfs_pkg::*;

  localparam int CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic [CMP_W-1:0] sample_x;
  logic [CMP_W-1:0] thresh_x;

  // widen both sides to a common width
  assign sample_x = CMP_W'(sample);
  assign thresh_x = CMP_W'(threshold);

  // dark reading below threshold means the sensor sees the line
  assign on_line = (sample_x < thresh_x);

endmodule

### rtl/core/lfs_pattern_merge.sv
// lfs_pattern_merge: joins the lane hits into the line pattern with tape polarity
// depends on lfs_pkg
module lfs_pattern_merge (
  input  lfs_pkg::pattern_t hits,
  input  logic              white_tape,
  output lfs_pkg::pattern_t pattern
);
  import lfs_pkg::*;

  // dark tape inverts every sensor bit
  assign pattern = white_tape ? hits : (hits ^ PAT_ALL);

endmodule

### rtl/core/lfs_error_map.sv
// lfs_error_map: maps a line pattern to a steering error or a sideways translate
// depends on lfs_pkg
module lfs_error_map (
  input  lfs_pkg::pattern_t                   pattern,
  input  logic signed [lfs_pkg::ERR_W-1:0]    last_error,
  output lfs_pkg::decode_t                    dec
);
  import lfs_pkg::*;

  logic signed [ERR_W-1:0] err;
  logic                    toggle;

  // base error table
  always_comb begin
    err    = '0;
    toggle = 1'b0;
    case (pattern)
      PAT_FR:                                err = ERR_SMALL;
      PAT_FL:                                err = -ERR_SMALL;
      PAT_CR, PAT_CR | PAT_RR:               err = ERR_BIG;
      PAT_CL, PAT_CL | PAT_RL:               err = -ERR_BIG;
      PAT_FR | PAT_CR, PAT_RL | PAT_FR,
      PAT_RL | PAT_CR:                       err = ERR_MID;
      PAT_FL | PAT_CL, PAT_RR | PAT_FL,
      PAT_RR | PAT_CL:                       err = -ERR_MID;
      PAT_ALL:                               toggle = 1'b1;
      default:                               err = '0;
    endcase
    // hold a hard turn while the line is lost off one side
    if ((pattern == PAT_NONE || pattern == PAT_RR || pattern == (PAT_RL | PAT_CL)) &&
        last_error == ERR_BIG) begin
      err = ERR_BIG;
    end
    if ((pattern == PAT_NONE || pattern == PAT_RL || pattern == (PAT_RL | PAT_CL)) &&
        last_error == -ERR_BIG) begin
      err = -ERR_BIG;
    end
  end

  // translate start patterns
  always_comb begin
    dec.err    = err;
    dec.toggle = toggle;
    dec.start  = (pattern == (PAT_FR | PAT_RR)) || (pattern == (PAT_FR | PAT_CR | PAT_RR)) ||
                 (pattern == (PAT_FL | PAT_RL)) || (pattern == (PAT_FL | PAT_CL | PAT_RL));
    dec.dir    = pattern[1] ? ACT_RIGHT : ACT_LEFT;
  end

endmodule

### rtl/core/lfs_serial_div.sv
// lfs_serial_div: restoring divider for the derivative, one quotient bit per cycle
// depends on lfs_pkg
module lfs_serial_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lfs_pkg::div_req_t             req,
  input  logic [lfs_pkg::TIME_W-1:0]    dividend,
  input  logic [lfs_pkg::SECS_W-1:0]    divisor,
  output lfs_pkg::div_stat_t            stat,
  output logic [lfs_pkg::TIME_W-1:0]    quotient
);
  import lfs_pkg::*;

  logic [TIME_W-1:0] dvd_r;
  logic [SECS_W:0]   rem_r;
  logic [SECS_W-1:0] dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [SECS_W:0]   shifted;
  logic              fits;

  // one trial subtraction
  assign shifted = {rem_r[SECS_W-1:0], dvd_r[TIME_W-1]};
  assign fits    = (shifted >= {1'b0, dsr_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[TIME_W-2:0], fits};
      rem_r <= fits ? (shifted - {1'b0, dsr_r}) : shifted;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

endmodule

### rtl/core/line_follower_pd_steering_core.sv
// line_follower_pd_steering_core: top level of the line follower steering core
// depends on lfs_pkg, lfs_sensor_lane, lfs_pattern_merge, lfs_error_map, lfs_serial_div
//
// Six reflectance samples and a millisecond timestamp go in as one transfer; one motor
// command comes out for each. Six threshold lanes build the line pattern in the cycle the
// transfer is taken, a decode step picks a steering error or a sideways translate, and a
// PD step with Q2.8 gains produces clamped left and right drives. A translate result
// goes from the decode state straight to the output state; an unchanged error passes
// the decode, multiply, sum and output states; a changed error with under a second
// elapsed also passes the seconds state before the multiply. Otherwise elapsed
// milliseconds become whole seconds by a reciprocal multiply and the serial divider
// divides the error by them in 10 steps in the derivative state before the multiply.
// One item is in flight at a time; a finished result sits in the output register and
// the next sample is taken while it waits. A second finished item holds in the output
// step, with input closed, until the waiting result is taken.
module line_follower_pd_steering_core #(
  parameter int SAMPLE_BITS = 12,
  localparam int IN_W =
    ((lfs_pkg::SENSOR_COUNT * SAMPLE_BITS + lfs_pkg::TIME_W + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // fields from bit 0: front_left_sample, front_right_sample, center_left_sample,
  // center_right_sample, rear_left_sample, rear_right_sample, time_ms, zero fill
  input  logic [IN_W-1:0]                   in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fields from bit 0: left_drive, right_drive, error_value, line_pattern, zero fill
  output logic [lfs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // fields from bit 0: action
  output logic [lfs_pkg::OUT_USER_W-1:0]    out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [lfs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lfs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lfs_pkg::*;

  // configuration
  logic [THRESH_W-1:0] threshold_r;
  logic [SPEED_W-1:0]  base_speed_r;
  logic [GAIN_W-1:0]   kp_gain_r;
  logic [GAIN_W-1:0]   kd_gain_r;

  // controller state
  state_t                  state_r, state_nxt;
  logic                    white_tape_r;
  logic signed [ERR_W-1:0] last_err_r;
  logic [TIME_W-1:0]       last_time_r;
  logic                    trans_active_r;
  action_t                 trans_dir_r;

  // item registers
  pattern_t                 pattern_r;
  logic [TIME_W-1:0]        time_r;
  logic [TIME_W-1:0]        elapsed_r;
  logic signed [ERR_W-1:0]  err_r;
  logic                     chg_r;
  logic                     shrink_r;
  logic signed [ERR_W-1:0]  deriv_r;
  logic signed [PROD_W-1:0] prod_p_r;
  logic signed [PROD_W-1:0] prod_d_r;
  logic [DRIVE_W-1:0]       res_left_r;
  logic [DRIVE_W-1:0]       res_right_r;
  action_t                  res_action_r;
  logic signed [ERR_W-1:0]  res_err_r;

  // output register
  logic                    out_valid_r;
  logic [DRIVE_W-1:0]      out_left_r;
  logic [DRIVE_W-1:0]      out_right_r;
  action_t                 out_action_r;
  logic [ERR_W-1:0]        out_err_r;
  pattern_t                out_pattern_r;

  // sensor lanes and merge
  pattern_t hits;
  pattern_t pattern;

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lfs_sensor_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .sample    (in_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .threshold (threshold_r),
      .on_line   (hits[g])
    );
  end

  lfs_pattern_merge u_merge (
    .hits       (hits),
    .white_tape (white_tape_r),
    .pattern    (pattern)
  );

  // pattern decode
  decode_t dec;

  lfs_error_map u_map (
    .pattern    (pattern_r),
    .last_error (last_err_r),
    .dec        (dec)
  );

  // derivative divider
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [TIME_W-1:0] div_dividend;
  logic [SECS_W-1:0] div_divisor;
  logic [TIME_W-1:0] div_quot;

  lfs_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // decode helpers
  logic                    front_hit;
  logic                    trans_out;
  logic signed [ERR_W-1:0] e_sel;
  logic [MAG_W-1:0]        e_sel_mag;
  logic [MAG_W-1:0]        last_mag;
  logic [MAG_W-1:0]        err_mag;
  logic [TIME_W-1:0]       elapsed;
  logic [TIME_W+SECS_RECIP_W-1:0] secs_prod;
  logic [SECS_W-1:0]       secs;
  logic                    out_load;

  assign front_hit = pattern_r[0] | pattern_r[1];
  assign trans_out = trans_active_r ? front_hit : dec.start;
  assign e_sel     = trans_active_r ? '0 : dec.err;
  assign e_sel_mag = e_sel[ERR_W-1] ? MAG_W'(-e_sel) : MAG_W'(e_sel);
  assign last_mag  = last_err_r[ERR_W-1] ? MAG_W'(-last_err_r) : MAG_W'(last_err_r);
  assign err_mag   = err_r[ERR_W-1] ? MAG_W'(-err_r) : MAG_W'(err_r);
  assign elapsed   = time_r - last_time_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // whole seconds by reciprocal multiplication
  assign secs_prod = elapsed_r * SECS_RECIP;
  assign secs      = secs_prod[SECS_SHIFT +: SECS_W];

  // next state and divider requests
  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    div_req.start = 1'b0;
    div_req.steps = DERIV_STEPS;
    div_dividend  = {err_mag, {(TIME_W-MAG_W){1'b0}}};
    div_divisor   = secs;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (trans_out) begin
          state_nxt = S_OUT;
        end else if (e_sel != last_err_r) begin
          state_nxt = S_SECS;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SECS: begin
        if (secs == '0) begin
          state_nxt = S_MUL;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DERIV;
        end
      end
      S_DERIV: begin
        if (div_stat.done) state_nxt = S_MUL;
      end
      S_MUL:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESH_W'(800);
      base_speed_r <= SPEED_W'(50);
      kp_gain_r    <= GAIN_W'(38);
      kd_gain_r    <= GAIN_W'(154);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD:  threshold_r  <= cfg_wdata[THRESH_W-1:0];
        REG_BASE_SPEED: base_speed_r <= cfg_wdata[SPEED_W-1:0];
        REG_KP_GAIN:    kp_gain_r    <= cfg_wdata[GAIN_W-1:0];
        REG_KD_GAIN:    kd_gain_r    <= cfg_wdata[GAIN_W-1:0];
        default:        threshold_r  <= threshold_r;
      endcase
    end
  end

  // persistent steering state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      white_tape_r   <= 1'b1;
      last_err_r     <= '0;
      last_time_r    <= '0;
      trans_active_r <= 1'b0;
      trans_dir_r    <= ACT_LEFT;
    end else begin
      case (state_r)
        S_DECODE: begin
          if (trans_active_r) begin
            if (!front_hit) trans_active_r <= 1'b0;
          end else if (dec.start) begin
            trans_active_r <= 1'b1;
            trans_dir_r    <= dec.dir;
          end else if (dec.toggle) begin
            white_tape_r <= ~white_tape_r;
          end
          if (!trans_out && e_sel != last_err_r) last_time_r <= time_r;
        end
        S_MUL: begin
          if (chg_r) last_err_r <= err_r;
        end
        default: last_err_r <= last_err_r;
      endcase
    end
  end

  // pd arithmetic helpers
  logic signed [PROD_W:0]    sum;
  logic signed [PROD_W:0]    biased;
  logic signed [PROD_W:0]    shifted;
  logic signed [15:0]        speed;
  logic signed [15:0]        base_x;
  logic                      pivot;
  logic signed [15:0]        left_raw;
  logic signed [15:0]        right_raw;
  logic [DRIVE_W-1:0]        left_sat;
  logic [DRIVE_W-1:0]        right_sat;
  logic signed [ERR_W-1:0]   q_signed;
  logic [MAG_W-1:0]          q_mag;

  // divide by 256 truncating toward zero, then mix and clamp
  always_comb begin
    sum     = {prod_p_r[PROD_W-1], prod_p_r} + {prod_d_r[PROD_W-1], prod_d_r};
    biased  = sum[PROD_W] ? (sum + (PROD_W+1)'(255)) : sum;
    shifted = biased >>> 8;
    speed   = shifted[15:0];
    base_x  = {{(16-SPEED_W){1'b0}}, base_speed_r};
    pivot   = (err_r == ERR_BIG) || (err_r == -ERR_BIG);
    left_raw  = pivot ? speed : (base_x + speed);
    right_raw = pivot ? -speed : (base_x - speed);
    if (left_raw > 16'sd127)       left_sat = 8'sd127;
    else if (left_raw < -16'sd127) left_sat = -8'sd127;
    else                           left_sat = left_raw[DRIVE_W-1:0];
    if (right_raw > 16'sd127)       right_sat = 8'sd127;
    else if (right_raw < -16'sd127) right_sat = -8'sd127;
    else                            right_sat = right_raw[DRIVE_W-1:0];
  end

  // derivative sign: follows the error, flipped when the error shrinks
  assign q_mag    = div_quot[MAG_W-1:0];
  assign q_signed = (err_r[ERR_W-1] ^ shrink_r) ? -$signed({1'b0, q_mag})
                                                : $signed({1'b0, q_mag});

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        pattern_r <= pattern;
        time_r    <= in_tdata[SENSOR_COUNT*SAMPLE_BITS +: TIME_W];
      end
      S_DECODE: begin
        elapsed_r <= elapsed;
        err_r    <= e_sel;
        chg_r    <= (e_sel != last_err_r);
        shrink_r <= (last_mag > e_sel_mag);
        deriv_r  <= '0;
        res_left_r   <= {1'b0, base_speed_r};
        res_right_r  <= {1'b0, base_speed_r};
        res_action_r <= trans_active_r ? trans_dir_r : dec.dir;
        res_err_r    <= '0;
      end
      S_DERIV: begin
        if (div_stat.done) deriv_r <= q_signed;
      end
      S_MUL: begin
        prod_p_r <= $signed({1'b0, kp_gain_r}) * err_r;
        prod_d_r <= $signed({1'b0, kd_gain_r}) * deriv_r;
      end
      S_SUM: begin
        res_left_r   <= left_sat;
        res_right_r  <= right_sat;
        res_action_r <= pivot ? ACT_PIVOT : ACT_DIFF;
        res_err_r    <= err_r;
      end
      default: res_err_r <= res_err_r;
    endcase
  end

  // output register, holds a loaded result while the next item can already come in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_left_r    <= res_left_r;
      out_right_r   <= res_right_r;
      out_action_r  <= res_action_r;
      out_err_r     <= res_err_r;
      out_pattern_r <= pattern_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*DRIVE_W-ERR_W-SENSOR_COUNT){1'b0}},
                       out_pattern_r, out_err_r, out_right_r, out_left_r};
  assign out_tuser  = out_action_r;

endmodule
